@@ hdl/shc_pkg.sv @@
// Shared types, constants and fixed-point helpers for the stereo headphone crossfeed.
// Used by the channel interfaces, the multiplier and the top level.
package shc_pkg;

    localparam int DEFAULT_DELAY_DEPTH = 1024;
    localparam int DEFAULT_SAMPLE_BITS = 24;

    localparam int COEF_FRAC    = 22;
    localparam int MID_FRAC     = 6;
    localparam int BYPASS_LIMIT = 65;
    localparam int ACC_W        = 64;
    localparam int MUL_A_W      = 41;
    localparam int MUL_B_W      = 25;
    localparam int OPER_W       = 41;
    localparam int LP_W         = 32;
    localparam int MIX_W        = 17;
    localparam int TAPS_W       = 10;
    localparam int COEF_W       = 24;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;
    localparam int STEP_W       = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_C   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_D   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_GAIN = 3'd7;

    localparam logic              MODE_NATURAL = 1'b0;
    localparam logic              MODE_BS2B    = 1'b1;
    localparam logic signed [23:0] UNITY_Q22   = 24'sh400000;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_BS     = 5'b00100,
        S_NAT    = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    // round half up, then arithmetic shift right
    function automatic logic signed [ACC_W-1:0] rshr(input logic signed [ACC_W-1:0] v,
                                                     input int sh);
        logic signed [ACC_W-1:0] t;
        if (sh == 0) begin
            return v;
        end
        t = v + (64'sd1 <<< (sh - 1));
        return t >>> sh;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat(input logic signed [ACC_W-1:0] v,
                                                    input int bits);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

@@ hdl/shc_in_if.sv @@
// Input channel: valid/ready handshake carrying one stereo sample pair.
// Default width comes from shc_pkg.
interface shc_in_if #(parameter int SAMPLE_BITS = shc_pkg::DEFAULT_SAMPLE_BITS);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

@@ hdl/shc_out_if.sv @@
// Output channel: valid/ready handshake carrying one crossfed stereo pair.
// Default width comes from shc_pkg.
interface shc_out_if #(parameter int SAMPLE_BITS = shc_pkg::DEFAULT_SAMPLE_BITS);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

@@ hdl/shc_mul.sv @@
// Shared signed multiplier with a registered product.
// Widths come from shc_pkg.
module shc_mul (
    input  logic                                 i_clk,
    input  logic signed [shc_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [shc_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [shc_pkg::ACC_W-1:0]     o_prod
);
    logic signed [shc_pkg::MUL_A_W+shc_pkg::MUL_B_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod[shc_pkg::ACC_W-1:0];
endmodule

@@ hdl/shc_ram.sv @@
// Delay line RAM: one write port, one read port with registered read data.
// No package dependency.
module shc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/stereo_headphone_crossfeed.sv @@
// Stereo headphone crossfeed top level: config registers, sequencer, filter state.
// Depends on shc_pkg, shc_in_if, shc_out_if, shc_mul and shc_ram.
//
// Usage:
//   i_in carries one stereo pair per word (valid/ready); o_out returns one
//   crossfed pair per input word, in order. Config registers are written through
//   i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while the
//   block is idle, and the block itself does not enforce it. One shared multiplier
//   with a registered product does all the filter math, stepped by a small sequencer.
//   Path from accept to the result being offered on o_out:
//     bypass (mix_amount <= 0.001)  input pair goes straight to the output register
//     natural delay mode            RAM read, then 8 multiplies
//     BS2B shelf mode               14 multiplies
//   The block takes one word at a time; i_in is ready only while it is idle.
//   After reset the delay RAM is swept to zero, one entry a cycle, and i_in is
//   not ready until the sweep ends; config writes are taken meanwhile.
//   The output register holds a finished pair while o_out is stalled; the next
//   word is accepted and computed, then waits until the output register frees.
module stereo_headphone_crossfeed #(
    parameter int DELAY_DEPTH = shc_pkg::DEFAULT_DELAY_DEPTH,
    parameter int SAMPLE_BITS = shc_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    shc_in_if.sink                              i_in,
    shc_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [shc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [shc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    localparam int SB = SAMPLE_BITS;
    localparam int SF = (SB < 30) ? 30 - SB : 0;
    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int TW = ((AW > shc_pkg::TAPS_W) ? AW : shc_pkg::TAPS_W) + 1;
    localparam int CF = shc_pkg::COEF_FRAC;
    localparam int NAT_SH = 23 + SF - shc_pkg::MID_FRAC;
    localparam int OUT_SH = shc_pkg::COEF_FRAC + shc_pkg::MID_FRAC;
    localparam int MIX_SH = 16 + SF;
    localparam int AC = shc_pkg::ACC_W;

    // configuration
    logic                                 r_mode;
    logic [shc_pkg::MIX_W-1:0]            r_mix;
    logic [shc_pkg::TAPS_W-1:0]           r_taps;
    logic signed [shc_pkg::COEF_W-1:0]    r_ca, r_cb, r_cc, r_cd, r_g;

    // control and filter state
    shc_pkg::t_state                      r_state, n_state;
    logic [shc_pkg::STEP_W-1:0]           r_step, n_step;
    logic [AW-1:0]                        r_clr, n_clr;
    logic [AW-1:0]                        r_wp, n_wp;
    logic signed [shc_pkg::LP_W-1:0]      r_lo_l, n_lo_l, r_lo_r, n_lo_r;
    logic signed [shc_pkg::LP_W-1:0]      r_hi_l, n_hi_l, r_hi_r, n_hi_r;
    logic signed [shc_pkg::LP_W-1:0]      r_lp_l, n_lp_l, r_lp_r, n_lp_r;
    logic signed [SB-1:0]                 r_prev_l, n_prev_l, r_prev_r, n_prev_r;
    logic                                 r_ov, n_ov;

    // datapath
    logic signed [SB-1:0]                 r_l, n_l, r_r, n_r;
    logic signed [SB-1:0]                 r_res_l, n_res_l, r_res_r, n_res_r;
    logic signed [SB-1:0]                 r_ol, n_ol, r_or, n_or;
    logic signed [AC-1:0]                 r_acc, n_acc;
    logic signed [shc_pkg::OPER_W-1:0]    r_tmp, n_tmp, r_tmp2, n_tmp2;

    logic signed [shc_pkg::MUL_A_W-1:0]   w_mul_a;
    logic signed [shc_pkg::MUL_B_W-1:0]   w_mul_b;
    logic signed [AC-1:0]                 w_p;

    logic                                 w_ram_we;
    logic [AW-1:0]                        w_ram_waddr;
    logic [2*SB-1:0]                      w_ram_wdata;
    logic [AW-1:0]                        w_rd;
    logic [2*SB-1:0]                      w_ram_rdata;

    logic [TW-1:0]                        w_taps;
    logic [TW-1:0]                        w_wpx;
    logic [TW-1:0]                        w_rdx;
    logic signed [SB-1:0]                 w_dl, w_dr;
    logic signed [AC-1:0]                 w_inf_l, w_inf_r, w_pv_l, w_pv_r, w_mid2;
    logic signed [AC-1:0]                 w_acc22;
    logic                                 w_accept;

    shc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_p)
    );

    shc_ram #(
        .DEPTH (DELAY_DEPTH),
        .WIDTH (2 * SB)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_rd),
        .o_rdata (w_ram_rdata)
    );

    assign i_in.ready      = (r_state == shc_pkg::S_IDLE);
    assign w_accept        = i_in.valid && i_in.ready;
    assign o_out.valid     = r_ov;
    assign o_out.left_out  = r_ol;
    assign o_out.right_out = r_or;

    // read tap: delay clamped to 1 .. DELAY_DEPTH-1, wrapped around the ring
    always_comb begin
        w_taps = TW'(r_taps);
        if (w_taps == '0) begin
            w_taps = TW'(1);
        end else if (w_taps > TW'(DELAY_DEPTH - 1)) begin
            w_taps = TW'(DELAY_DEPTH - 1);
        end
        w_wpx = TW'(r_wp);
        if (w_wpx >= w_taps) begin
            w_rdx = w_wpx - w_taps;
        end else begin
            w_rdx = w_wpx + TW'(DELAY_DEPTH) - w_taps;
        end
        w_rd = w_rdx[AW-1:0];
    end

    assign w_dl    = signed'(w_ram_rdata[2*SB-1:SB]);
    assign w_dr    = signed'(w_ram_rdata[SB-1:0]);
    assign w_inf_l = AC'(r_l) <<< SF;
    assign w_inf_r = AC'(r_r) <<< SF;
    assign w_pv_l  = AC'(r_prev_l) <<< SF;
    assign w_pv_r  = AC'(r_prev_r) <<< SF;
    assign w_mid2  = AC'(r_l) + AC'(r_r);
    assign w_acc22 = shc_pkg::rshr(r_acc, CF);

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_clr    = r_clr;
        n_wp     = r_wp;
        n_lo_l   = r_lo_l;
        n_lo_r   = r_lo_r;
        n_hi_l   = r_hi_l;
        n_hi_r   = r_hi_r;
        n_lp_l   = r_lp_l;
        n_lp_r   = r_lp_r;
        n_prev_l = r_prev_l;
        n_prev_r = r_prev_r;
        n_ov     = r_ov;
        n_l      = r_l;
        n_r      = r_r;
        n_res_l  = r_res_l;
        n_res_r  = r_res_r;
        n_ol     = r_ol;
        n_or     = r_or;
        n_acc    = r_acc;
        n_tmp    = r_tmp;
        n_tmp2   = r_tmp2;
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_wp;
        w_ram_wdata = {r_l, r_r};

        // drop the output word once taken
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            shc_pkg::S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr;
                w_ram_wdata = '0;
                n_clr       = r_clr + AW'(1);
                if (r_clr == AW'(DELAY_DEPTH - 1)) begin
                    n_state = shc_pkg::S_IDLE;
                end
            end
            shc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_l    = i_in.left_in;
                    n_r    = i_in.right_in;
                    n_step = '0;
                    if (r_mix <= shc_pkg::MIX_W'(shc_pkg::BYPASS_LIMIT)) begin
                        n_res_l = i_in.left_in;
                        n_res_r = i_in.right_in;
                        n_state = shc_pkg::S_FINISH;
                    end else if (r_mode == shc_pkg::MODE_BS2B) begin
                        n_state = shc_pkg::S_BS;
                    end else begin
                        n_state = shc_pkg::S_NAT;
                    end
                end
            end
            shc_pkg::S_BS: begin
                n_step = r_step + 5'd1;
                case (r_step)
                    5'd0: begin
                        w_mul_a = 41'(w_inf_l); w_mul_b = 25'(r_ca);
                    end
                    5'd1: begin
                        n_acc = w_p;
                        w_mul_a = 41'(r_lo_l); w_mul_b = 25'(r_cb);
                    end
                    5'd2: begin
                        n_acc = r_acc + w_p;
                        w_mul_a = 41'(w_inf_l); w_mul_b = 25'(r_cc);
                    end
                    5'd3: begin
                        n_lo_l = 32'(shc_pkg::sat(w_acc22, 32));
                        n_acc = w_p;
                        w_mul_a = 41'(w_pv_l); w_mul_b = 25'(r_cd);
                    end
                    5'd4: begin
                        n_acc = r_acc - w_p;
                        w_mul_a = 41'(r_hi_l); w_mul_b = 25'(r_cd);
                    end
                    5'd5: begin
                        n_acc = r_acc + w_p;
                        w_mul_a = 41'(w_inf_r); w_mul_b = 25'(r_ca);
                    end
                    5'd6: begin
                        n_hi_l   = 32'(shc_pkg::sat(w_acc22, 32));
                        n_prev_l = r_l;
                        n_acc    = w_p;
                        w_mul_a = 41'(r_lo_r); w_mul_b = 25'(r_cb);
                    end
                    5'd7: begin
                        n_acc = r_acc + w_p;
                        w_mul_a = 41'(w_inf_r); w_mul_b = 25'(r_cc);
                    end
                    5'd8: begin
                        n_lo_r = 32'(shc_pkg::sat(w_acc22, 32));
                        n_acc = w_p;
                        w_mul_a = 41'(w_pv_r); w_mul_b = 25'(r_cd);
                    end
                    5'd9: begin
                        n_acc = r_acc - w_p;
                        w_mul_a = 41'(r_hi_r); w_mul_b = 25'(r_cd);
                    end
                    5'd10: begin
                        n_acc = r_acc + w_p;
                        w_mul_a = 41'(AC'(r_hi_l) + AC'(r_lo_r)); w_mul_b = 25'(r_g);
                    end
                    5'd11: begin
                        n_hi_r   = 32'(shc_pkg::sat(w_acc22, 32));
                        n_prev_r = r_r;
                        n_acc    = w_p;
                    end
                    5'd12: begin
                        n_tmp = 41'(w_acc22 - w_inf_l);
                        w_mul_a = 41'(AC'(r_hi_r) + AC'(r_lo_l)); w_mul_b = 25'(r_g);
                    end
                    5'd13: begin
                        n_acc = w_p;
                        w_mul_a = r_tmp; w_mul_b = 25'({1'b0, r_mix});
                    end
                    5'd14: begin
                        n_tmp = 41'(w_acc22 - w_inf_r);
                        n_acc = (w_inf_l <<< 16) + w_p;
                    end
                    5'd15: begin
                        n_res_l = SB'(shc_pkg::sat(shc_pkg::rshr(r_acc, MIX_SH), SB));
                        w_mul_a = r_tmp; w_mul_b = 25'({1'b0, r_mix});
                    end
                    5'd16: begin
                        n_acc = (w_inf_r <<< 16) + w_p;
                    end
                    default: begin
                        n_res_r = SB'(shc_pkg::sat(shc_pkg::rshr(r_acc, MIX_SH), SB));
                        n_state = shc_pkg::S_FINISH;
                    end
                endcase
            end
            shc_pkg::S_NAT: begin
                n_step = r_step + 5'd1;
                case (r_step)
                    5'd0: begin
                        // write this pair and read the delayed one
                        w_ram_we = 1'b1;
                    end
                    5'd1: begin
                        n_tmp  = 41'((AC'(w_dl) <<< SF) - AC'(r_lp_l));
                        n_tmp2 = 41'((AC'(w_dr) <<< SF) - AC'(r_lp_r));
                    end
                    5'd2: begin
                        w_mul_a = r_tmp; w_mul_b = 25'(r_ca);
                    end
                    5'd3: begin
                        n_acc = w_p;
                        w_mul_a = r_tmp2; w_mul_b = 25'(r_ca);
                    end
                    5'd4: begin
                        n_lp_l = 32'(shc_pkg::sat(AC'(r_lp_l) + w_acc22, 32));
                        n_acc  = w_p;
                    end
                    5'd5: begin
                        n_lp_r = 32'(shc_pkg::sat(AC'(r_lp_r) + w_acc22, 32));
                        w_mul_a = 41'(AC'(r_l) - AC'(r_r)); w_mul_b = 25'(r_cb);
                    end
                    5'd6: begin
                        n_acc = (w_p <<< SF) + (w_mid2 <<< (22 + SF));
                        w_mul_a = 41'(r_lp_r); w_mul_b = 25'(r_cc);
                    end
                    5'd7: begin
                        n_acc = r_acc + (w_p <<< 1);
                        w_mul_a = 41'(AC'(r_r) - AC'(r_l)); w_mul_b = 25'(r_cb);
                    end
                    5'd8: begin
                        n_tmp = 41'(shc_pkg::sat(shc_pkg::rshr(r_acc, NAT_SH), 40));
                        n_acc = (w_p <<< SF) + (w_mid2 <<< (22 + SF));
                        w_mul_a = 41'(r_lp_l); w_mul_b = 25'(r_cc);
                    end
                    5'd9: begin
                        n_acc = r_acc + (w_p <<< 1);
                        w_mul_a = r_tmp; w_mul_b = 25'(r_g);
                    end
                    5'd10: begin
                        n_tmp = 41'(shc_pkg::sat(shc_pkg::rshr(r_acc, NAT_SH), 40));
                        n_acc = w_p;
                    end
                    5'd11: begin
                        n_res_l = SB'(shc_pkg::sat(shc_pkg::rshr(r_acc, OUT_SH), SB));
                        w_mul_a = r_tmp; w_mul_b = 25'(r_g);
                    end
                    5'd12: begin
                        n_acc = w_p;
                    end
                    default: begin
                        n_res_r = SB'(shc_pkg::sat(shc_pkg::rshr(r_acc, OUT_SH), SB));
                        n_wp = (r_wp == AW'(DELAY_DEPTH - 1)) ? '0 : r_wp + AW'(1);
                        n_state = shc_pkg::S_FINISH;
                    end
                endcase
            end
            shc_pkg::S_FINISH: begin
                // hold the result until the output register is free
                if (!r_ov || o_out.ready) begin
                    n_ol    = r_res_l;
                    n_or    = r_res_r;
                    n_ov    = 1'b1;
                    n_state = shc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = shc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= shc_pkg::MODE_NATURAL;
            r_mix    <= '0;
            r_taps   <= shc_pkg::TAPS_W'(1);
            r_ca     <= '0;
            r_cb     <= '0;
            r_cc     <= shc_pkg::UNITY_Q22;
            r_cd     <= '0;
            r_g      <= shc_pkg::UNITY_Q22;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                shc_pkg::CFG_MODE:     r_mode <= i_cfg_data[0];
                shc_pkg::CFG_MIX:      r_mix  <= i_cfg_data[shc_pkg::MIX_W-1:0];
                shc_pkg::CFG_TAPS:     r_taps <= i_cfg_data[shc_pkg::TAPS_W-1:0];
                shc_pkg::CFG_COEF_A:   r_ca   <= signed'(i_cfg_data[shc_pkg::COEF_W-1:0]);
                shc_pkg::CFG_COEF_B:   r_cb   <= signed'(i_cfg_data[shc_pkg::COEF_W-1:0]);
                shc_pkg::CFG_COEF_C:   r_cc   <= signed'(i_cfg_data[shc_pkg::COEF_W-1:0]);
                shc_pkg::CFG_COEF_D:   r_cd   <= signed'(i_cfg_data[shc_pkg::COEF_W-1:0]);
                shc_pkg::CFG_OUT_GAIN: r_g    <= signed'(i_cfg_data[shc_pkg::COEF_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= shc_pkg::S_CLEAR;
            r_step   <= '0;
            r_clr    <= '0;
            r_wp     <= '0;
            r_lo_l   <= '0;
            r_lo_r   <= '0;
            r_hi_l   <= '0;
            r_hi_r   <= '0;
            r_lp_l   <= '0;
            r_lp_r   <= '0;
            r_prev_l <= '0;
            r_prev_r <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_clr    <= n_clr;
            r_wp     <= n_wp;
            r_lo_l   <= n_lo_l;
            r_lo_r   <= n_lo_r;
            r_hi_l   <= n_hi_l;
            r_hi_r   <= n_hi_r;
            r_lp_l   <= n_lp_l;
            r_lp_r   <= n_lp_r;
            r_prev_l <= n_prev_l;
            r_prev_r <= n_prev_r;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l     <= n_l;
        r_r     <= n_r;
        r_res_l <= n_res_l;
        r_res_r <= n_res_r;
        r_ol    <= n_ol;
        r_or    <= n_or;
        r_acc   <= n_acc;
        r_tmp   <= n_tmp;
        r_tmp2  <= n_tmp2;
    end

`ifndef ASSERT_OFF
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == shc_pkg::S_FINISH))
        else $error("output word appeared without a finished item");

    a_bs2b_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_mode == shc_pkg::MODE_BS2B &&
         r_mix > shc_pkg::MIX_W'(shc_pkg::BYPASS_LIMIT)) |=> (r_state == shc_pkg::S_BS))
        else $error("BS2B word did not start the shelf sequence");

    a_wp_moves_in_natural: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp != $past(r_wp)) |-> $past(r_state == shc_pkg::S_NAT))
        else $error("ring write position moved outside natural mode");
`endif

endmodule

@@ tb/stereo_headphone_crossfeed_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the stereo headphone crossfeed: watches config writes and both channels,
// predicts each crossfed pair and compares it. Depends on shc_pkg, shc_in_if and shc_out_if.
module stereo_headphone_crossfeed_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    shc_in_if                                 i_in,
    shc_out_if                                i_out,
    input  logic                              i_cfg_we,
    input  logic [shc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [shc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int                                o_errors,
    output int                                o_pending
);
    localparam int DEPTH  = 1024;
    localparam int SFRAC  = 6;

    typedef struct packed {
        logic signed [23:0] left;
        logic signed [23:0] right;
    } t_pair;

    // shadow registers
    logic        cur_mode;
    logic [16:0] cur_mix;
    logic [9:0]  cur_taps;
    longint      ca, cb, cc, cd, cg;

    // shadow filter state
    longint      ring_l [DEPTH];
    longint      ring_r [DEPTH];
    int          wr_idx;
    longint      nat_lp_l, nat_lp_r;
    longint      sh_lo_l, sh_lo_r, sh_hi_l, sh_hi_r, last_l, last_r;

    t_pair       pending_pairs [$];

    assign o_pending = pending_pairs.size();

    function automatic longint round_shift(longint v, int sh);
        if (sh == 0) begin
            return v;
        end
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clip(longint v, int bits);
        longint hi;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        if (v > hi) begin
            return hi;
        end
        if (v < -hi - 1) begin
            return -hi - 1;
        end
        return v;
    endfunction

    function automatic longint shelf_mix(longint x, longint hi, longint lo_other);
        longint wet;
        longint xs;
        wet = round_shift((hi + lo_other) * cg, shc_pkg::COEF_FRAC);
        xs  = x <<< SFRAC;
        return round_shift(xs * 65536 + longint'(cur_mix) * (wet - xs), 16 + SFRAC);
    endfunction

    function automatic longint natural_mix(longint mid2, longint diff, longint lp_other);
        longint acc;
        longint t;
        acc = mid2 * (64'sd1 <<< (22 + SFRAC)) + diff * cb * (64'sd1 <<< SFRAC)
              + cc * lp_other * 2;
        t = clip(round_shift(acc, 23 + SFRAC - shc_pkg::MID_FRAC), 40);
        return round_shift(t * cg, shc_pkg::COEF_FRAC + shc_pkg::MID_FRAC);
    endfunction

    function automatic t_pair crossfeed_pair(longint l, longint r);
        t_pair  res;
        longint ol, orr, dl, dr;
        int     taps, rd;
        if (cur_mix <= shc_pkg::BYPASS_LIMIT) begin
            ol  = l;
            orr = r;
        end else if (cur_mode == shc_pkg::MODE_BS2B) begin
            sh_lo_l = clip(round_shift(ca * (l <<< SFRAC) + cb * sh_lo_l,
                                       shc_pkg::COEF_FRAC), 32);
            sh_hi_l = clip(round_shift(cc * (l <<< SFRAC) - cd * (last_l <<< SFRAC)
                                       + cd * sh_hi_l, shc_pkg::COEF_FRAC), 32);
            last_l  = l;
            sh_lo_r = clip(round_shift(ca * (r <<< SFRAC) + cb * sh_lo_r,
                                       shc_pkg::COEF_FRAC), 32);
            sh_hi_r = clip(round_shift(cc * (r <<< SFRAC) - cd * (last_r <<< SFRAC)
                                       + cd * sh_hi_r, shc_pkg::COEF_FRAC), 32);
            last_r  = r;
            ol  = shelf_mix(l, sh_hi_l, sh_lo_r);
            orr = shelf_mix(r, sh_hi_r, sh_lo_l);
        end else begin
            taps = cur_taps;
            if (taps < 1) begin
                taps = 1;
            end
            if (taps > DEPTH - 1) begin
                taps = DEPTH - 1;
            end
            ring_l[wr_idx] = l;
            ring_r[wr_idx] = r;
            rd = (wr_idx >= taps) ? wr_idx - taps : wr_idx + DEPTH - taps;
            dl = ring_l[rd];
            dr = ring_r[rd];
            nat_lp_l = clip(nat_lp_l + round_shift(ca * ((dl <<< SFRAC) - nat_lp_l),
                                                   shc_pkg::COEF_FRAC), 32);
            nat_lp_r = clip(nat_lp_r + round_shift(ca * ((dr <<< SFRAC) - nat_lp_r),
                                                   shc_pkg::COEF_FRAC), 32);
            ol  = natural_mix(l + r, l - r, nat_lp_r);
            orr = natural_mix(l + r, r - l, nat_lp_l);
            wr_idx = (wr_idx + 1 >= DEPTH) ? 0 : wr_idx + 1;
        end
        res.left  = 24'(clip(ol, 24));
        res.right = 24'(clip(orr, 24));
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pair got;
        t_pair want;
        t_pair pred;
        if (!i_rst_n) begin
            cur_mode = shc_pkg::MODE_NATURAL;
            cur_mix  = '0;
            cur_taps = 10'd1;
            ca = 0; cb = 0; cc = 4194304; cd = 0; cg = 4194304;
            for (int k = 0; k < DEPTH; k++) begin
                ring_l[k] = 0;
                ring_r[k] = 0;
            end
            wr_idx = 0;
            nat_lp_l = 0; nat_lp_r = 0;
            sh_lo_l = 0; sh_lo_r = 0; sh_hi_l = 0; sh_hi_r = 0; last_l = 0; last_r = 0;
            pending_pairs.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    shc_pkg::CFG_MODE:     cur_mode = i_cfg_data[0];
                    shc_pkg::CFG_MIX:      cur_mix  = i_cfg_data[16:0];
                    shc_pkg::CFG_TAPS:     cur_taps = i_cfg_data[9:0];
                    shc_pkg::CFG_COEF_A:   ca = longint'($signed(i_cfg_data));
                    shc_pkg::CFG_COEF_B:   cb = longint'($signed(i_cfg_data));
                    shc_pkg::CFG_COEF_C:   cc = longint'($signed(i_cfg_data));
                    shc_pkg::CFG_COEF_D:   cd = longint'($signed(i_cfg_data));
                    shc_pkg::CFG_OUT_GAIN: cg = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                pred = crossfeed_pair(longint'(i_in.left_in), longint'(i_in.right_in));
                pending_pairs = {pending_pairs, pred};
            end
            if (i_out.valid && i_out.ready) begin
                got.left  = i_out.left_out;
                got.right = i_out.right_out;
                if (pending_pairs.size() == 0) begin
                    $error("unexpected output word left_out=%0d right_out=%0d",
                           got.left, got.right);
                    o_errors++;
                end else begin
                    want = pending_pairs.pop_front();
                    if (got.left !== want.left) begin
                        $error("left_out expected %0d actual %0d", want.left, got.left);
                        o_errors++;
                    end
                    if (got.right !== want.right) begin
                        $error("right_out expected %0d actual %0d", want.right, got.right);
                        o_errors++;
                    end
                end
            end
        end
    end
endmodule

@@ tb/stereo_headphone_crossfeed_test.sv @@
`timescale 1ns / 100ps
// Top of the crossfeed testbench: clock, reset, config phases and handshake stimulus.
// Depends on shc_pkg, the channel interfaces, the block and stereo_headphone_crossfeed_checker.
module stereo_headphone_crossfeed_test;
    localparam int STALL_LIMIT = 20000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [shc_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [shc_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             errors;
    int                             pending;
    bit                             quiet;
    bit                             hold_req;
    int                             idle_cycles;

    shc_in_if  in_ch ();
    shc_out_if out_ch ();

    stereo_headphone_crossfeed dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    stereo_headphone_crossfeed_checker scoreboard (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver: random backpressure, one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                out_ch.ready <= quiet || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input logic [shc_pkg::CFG_IDX_W-1:0] idx, input longint val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= shc_pkg::CFG_DATA_W'(val);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic send_pair(input logic [23:0] l, input logic [23:0] r);
        if (!quiet) begin
            while ($urandom_range(0, 99) < 10) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid    <= 1'b1;
        in_ch.left_in  <= l;
        in_ch.right_in <= r;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(0, 2000)) - 1000);
            default: return 24'($urandom);
        endcase
    endfunction

    // drain, then let the block settle before touching the registers
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_all(input logic m, input longint mix, input longint taps,
                           input longint a, input longint b, input longint c,
                           input longint d, input longint g);
        settle();
        write_reg(shc_pkg::CFG_MODE, m);
        write_reg(shc_pkg::CFG_MIX, mix);
        write_reg(shc_pkg::CFG_TAPS, taps);
        write_reg(shc_pkg::CFG_COEF_A, a);
        write_reg(shc_pkg::CFG_COEF_B, b);
        write_reg(shc_pkg::CFG_COEF_C, c);
        write_reg(shc_pkg::CFG_COEF_D, d);
        write_reg(shc_pkg::CFG_OUT_GAIN, g);
    endtask

    task automatic send_edges();
        send_pair(24'h7FFFFF, 24'h7FFFFF);
        send_pair(24'h800000, 24'h800000);
        send_pair(24'h7FFFFF, 24'h800000);
        send_pair(24'h000000, 24'hFFFFFF);
        send_pair(pick_sample(), pick_sample());
    endtask

    task automatic send_random(input int n);
        for (int k = 0; k < n; k++) begin
            send_pair(pick_sample(), pick_sample());
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.left_in  = '0;
        in_ch.right_in = '0;
        quiet          = 1'b0;
        hold_req       = 1'b0;
        idle_cycles    = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset values, bypass edge, just-active, both modes, largest taps
        send_edges();
        set_all(shc_pkg::MODE_NATURAL, 65, 0, 4194304, 8388607, 8388607, 0, 8388607);
        send_edges();
        set_all(shc_pkg::MODE_BS2B, 66, 1, 8388607, -8388608, -8388608, 8388607, -8388608);
        send_edges();
        set_all(shc_pkg::MODE_NATURAL, 65536, 1023, -8388608, 0, -8388608, -8388608,
                8388607);
        send_edges();
        set_all(shc_pkg::MODE_BS2B, 65536, 2, 419430, 3774873, 3774873, 3355443, 4194304);
        send_edges();

        // random phases
        set_all(shc_pkg::MODE_BS2B, 65536, 5, 419430, 3774873, 3774873, 3355443, 4194304);
        hold_req = 1'b1;
        send_random(180);
        set_all(shc_pkg::MODE_NATURAL, 32768, 17, 1258291, 4194304, 2097152, 0, 3355443);
        send_random(90);
        settle();
        send_random(90);
        set_all(shc_pkg::MODE_NATURAL, 65536, 1023, 2097152, 6291456, 4194304, 1234567,
                4194304);
        quiet = 1'b1;
        send_random(180);
        quiet = 1'b0;
        set_all(shc_pkg::MODE_BS2B, 20000, 3, 838861, 2516582, 4194304, 2936013, 2500000);
        send_random(180);
        set_all(shc_pkg::MODE_NATURAL, 0, 300, 1000000, 2000000, 3000000, 4000000, 5000000);
        send_random(180);
        for (int p = 0; p < 3; p++) begin
            set_all(1'($urandom_range(0, 1)), $urandom_range(66, 65536),
                    $urandom_range(0, 1023),
                    $signed(24'($urandom)), $signed(24'($urandom)), $signed(24'($urandom)),
                    $signed(24'($urandom)), $signed(24'($urandom)));
            send_random(180);
        end

        settle();
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
